// File: rtl/wmcls_pkg.sv
package wmcls_pkg;

	// Instruction codes carried in the opcode field
	typedef enum logic [2:0] {
		OP_SMULL  = 3'd0,
		OP_UMULL  = 3'd1,
		OP_SMADDL = 3'd2,
		OP_UMADDL = 3'd3,
		OP_SMULH  = 3'd4,
		OP_UMULH  = 3'd5,
		OP_CLS    = 3'd6,
		OP_UNSUP  = 3'd7
	} op_t;

	// Destination arrangement of the vector long multiplies
	typedef enum logic [1:0] {
		LAYOUT_SCALAR = 2'd0,
		LAYOUT_8H     = 2'd1,
		LAYOUT_4S     = 2'd2,
		LAYOUT_2D     = 2'd3
	} layout_t;

	// Internal class of work that travels down the pipeline
	typedef enum logic [2:0] {
		K_MUL_LOW = 3'd0,
		K_MADD    = 3'd1,
		K_MULH    = 3'd2,
		K_VEC8    = 3'd3,
		K_VEC4    = 3'd4,
		K_VEC2    = 3'd5,
		K_CLS     = 3'd6,
		K_NONE    = 3'd7
	} kind_t;

	localparam int WLANES    = 4;	// 33x33 multipliers: mulh partials, scalar, 2D lanes
	localparam int HLANES    = 4;	// 17x17 multipliers: 4S lanes
	localparam int BLANES    = 8;	// 9x9 multipliers: 8H lanes
	localparam int CHUNK_W   = 8;	// leading-zero count chunk width
	localparam int CLS_CHUNKS = 64 / CHUNK_W;

	typedef struct packed {
		op_t         opcode;
		layout_t     lane_layout;
		logic        b_by_element;
		logic [63:0] first_operand;
		logic [63:0] second_operand;
		logic [63:0] accumulator;
		logic        wide_mode;
	} req_t;

	typedef struct packed {
		logic [63:0] result_low;
		logic [63:0] result_high;
		logic        handled;
	} rsp_t;

	// Extended operands for every multiplier of the array
	typedef struct packed {
		logic [WLANES-1:0][32:0] wa;
		logic [WLANES-1:0][32:0] wb;
		logic [HLANES-1:0][16:0] ha;
		logic [HLANES-1:0][16:0] hb;
		logic [BLANES-1:0][8:0]  ba;
		logic [BLANES-1:0][8:0]  bb;
	} mul_ops_t;

	// Products, kept to the bits any consumer reads
	typedef struct packed {
		logic [WLANES-1:0][63:0] wp;
		logic [HLANES-1:0][31:0] hp;
		logic [BLANES-1:0][15:0] bp;
	} mul_prod_t;

endpackage

// File: rtl/wmcls_mul.sv
module wmcls_mul import wmcls_pkg::*; (
	input  logic      clk,
	input  logic      en,
	input  mul_ops_t  ops,
	output mul_prod_t prod_s2
);

	logic signed [65:0] wfull [WLANES];
	logic signed [33:0] hfull [HLANES];
	logic signed [17:0] bfull [BLANES];
	mul_prod_t          prod_d;

	// Multiply every lane as signed; zero-extended operands give unsigned products
	always_comb begin
		for (int i = 0; i < WLANES; i++) begin
			wfull[i] = $signed(ops.wa[i]) * $signed(ops.wb[i]);
			prod_d.wp[i] = wfull[i][63:0];
		end
		for (int i = 0; i < HLANES; i++) begin
			hfull[i] = $signed(ops.ha[i]) * $signed(ops.hb[i]);
			prod_d.hp[i] = hfull[i][31:0];
		end
		for (int i = 0; i < BLANES; i++) begin
			bfull[i] = $signed(ops.ba[i]) * $signed(ops.bb[i]);
			prod_d.bp[i] = bfull[i][15:0];
		end
	end

	// Hold products while the next stage stalls
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

// File: rtl/wmcls_cls.sv
module wmcls_cls import wmcls_pkg::*; (
	input  logic                            clk,
	input  logic                            en,
	input  logic [63:0]                     tw,
	output logic [CLS_CHUNKS-1:0][3:0]      cnt_s2
);

	logic [CLS_CHUNKS-1:0][3:0]        cnt_d;
	logic [CLS_CHUNKS-1:0][CHUNK_W-1:0] chunk;

	// Count leading zeros of each chunk; the highest set bit wins
	always_comb begin
		for (int c = 0; c < CLS_CHUNKS; c++) begin
			chunk[c] = tw[c*CHUNK_W +: CHUNK_W];
			cnt_d[c] = 4'(CHUNK_W);
			for (int j = 0; j < CHUNK_W; j++) begin
				if (chunk[c][j]) begin
					cnt_d[c] = 4'(CHUNK_W - 1 - j);
				end
			end
		end
	end

	// Hold chunk counts while the next stage stalls
	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s2 <= cnt_d;
		end
	end

endmodule

// File: rtl/widening_multiply_and_cls_unit_top.sv
// Widening multiply and count-leading-sign unit.
// req channel: one beat per instruction (req_t: opcode, lane layout,
//   by-element flag, three 64-bit operands, cls width), valid/ready.
// rsp channel: one beat per instruction (rsp_t: 128-bit result as low and
//   high words, handled flag), valid/ready, in the order of acceptance.
// Pipeline: a beat passes four register stages (operand select, multiplier
//   array, lane merge / partial sums, mulh carry and sign fix-up into the
//   output register) before rsp_valid rises; a stall can hold it in any stage.
// Throughput: one beat per cycle, sustained, for every opcode, as long as
//   rsp_ready is high.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty and
//   req_ready is high from the first cycle.
// Stall: when rsp_ready is low the output beat holds; each stage only stops
//   when the one after it is full, so bubbles close up and req_ready stays
//   high until all four stages hold a beat.
module widening_multiply_and_cls_unit_top import wmcls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	// Stage advance enables
	logic adv1, adv2, adv3, adv4;
	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1 signals
	kind_t      kind_d;
	logic       sg, xs, vec_bc;
	logic [63:0] a, b;
	logic [31:0] bh;
	logic [15:0] he_a, he_b;
	logic [7:0]  be_a, be_b;
	logic [31:0] v32, t32;
	mul_ops_t   ops_d;
	logic [63:0] corr_d, tw_d;

	kind_t      kind_s1;
	mul_ops_t   ops_s1;
	logic [63:0] acc_s1, corr_s1, tw_s1;

	// Stage 2 signals
	kind_t      kind_s2;
	logic [63:0] acc_s2, corr_s2;
	mul_prod_t  prod_s2;
	logic [CLS_CHUNKS-1:0][3:0] cnt_s2;

	// Stage 3 signals
	logic [63:0] lo_d, hi_d;
	logic [33:0] mid;
	logic [6:0]  lz;
	logic        run;
	kind_t      kind_s3;
	logic [63:0] lo_s3, hi_s3, corr_s3;
	logic [1:0]  carry_s3;

	// Stage 4 signals
	rsp_t rsp_d, rsp_s4;

	// Advance a stage when it is empty or the next one moves
	assign adv4      = !v_s4 || rsp_ready;
	assign adv3      = !v_s3 || adv4;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req_ready = adv1;
	assign rsp_valid = v_s4;
	assign rsp_data  = rsp_s4;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= req_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Decode the instruction and extend operands for the multiplier array
	always_comb begin
		a = req_data.first_operand;
		b = req_data.second_operand;
		sg = (req_data.opcode == OP_SMULL) || (req_data.opcode == OP_SMADDL) ||
			(req_data.opcode == OP_SMULH);
		unique case (req_data.opcode) inside
			OP_SMULL, OP_UMULL: begin
				unique case (req_data.lane_layout)
					LAYOUT_SCALAR: kind_d = K_MUL_LOW;
					LAYOUT_8H:     kind_d = K_VEC8;
					LAYOUT_4S:     kind_d = K_VEC4;
					LAYOUT_2D:     kind_d = K_VEC2;
					default:       kind_d = K_MUL_LOW;
				endcase
			end
			OP_SMADDL, OP_UMADDL: kind_d = K_MADD;
			OP_SMULH, OP_UMULH:   kind_d = K_MULH;
			OP_CLS:               kind_d = K_CLS;
			default:              kind_d = K_NONE;
		endcase
		// mulh partials are unsigned; the sign is fixed up at the end
		xs = sg && (kind_d != K_MULH);
		vec_bc = req_data.b_by_element && (kind_d != K_MULH);
		bh = vec_bc ? b[31:0] : b[63:32];

		ops_d.wa[0] = {xs & a[31], a[31:0]};
		ops_d.wb[0] = {xs & b[31], b[31:0]};
		ops_d.wa[1] = {xs & a[63], a[63:32]};
		ops_d.wb[1] = {xs & bh[31], bh};
		ops_d.wa[2] = {1'b0, a[31:0]};
		ops_d.wb[2] = {1'b0, b[63:32]};
		ops_d.wa[3] = {1'b0, a[63:32]};
		ops_d.wb[3] = {1'b0, b[31:0]};

		for (int i = 0; i < HLANES; i++) begin
			he_a = a[i*16 +: 16];
			he_b = req_data.b_by_element ? b[15:0] : b[i*16 +: 16];
			ops_d.ha[i] = {sg & he_a[15], he_a};
			ops_d.hb[i] = {sg & he_b[15], he_b};
		end
		for (int i = 0; i < BLANES; i++) begin
			be_a = a[i*8 +: 8];
			be_b = req_data.b_by_element ? b[7:0] : b[i*8 +: 8];
			ops_d.ba[i] = {sg & be_a[7], be_a};
			ops_d.bb[i] = {sg & be_b[7], be_b};
		end

		// Signed high product: subtract each operand when the other is negative
		corr_d = '0;
		if (req_data.opcode == OP_SMULH) begin
			corr_d = (a[63] ? b : 64'd0) + (b[63] ? a : 64'd0);
		end

		// Mark bits that differ from their left neighbor; pad 32-bit size
		v32 = a[31:0];
		t32 = v32 ^ {v32[31], v32[31:1]};
		if (req_data.wide_mode) begin
			tw_d = a ^ {a[63], a[63:1]};
		end else begin
			tw_d = {t32, 1'b1, 31'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s1 <= kind_d;
			ops_s1  <= ops_d;
			acc_s1  <= req_data.accumulator;
			corr_s1 <= corr_d;
			tw_s1   <= tw_d;
		end
	end

	// Stage 2: multiplier array and chunk counts
	wmcls_mul u_mul (
		.clk     (clk),
		.en      (adv2),
		.ops     (ops_s1),
		.prod_s2 (prod_s2)
	);

	wmcls_cls u_cls (
		.clk    (clk),
		.en     (adv2),
		.tw     (tw_s1),
		.cnt_s2 (cnt_s2)
	);

	always_ff @(posedge clk) begin
		if (adv2) begin
			kind_s2 <= kind_s1;
			acc_s2  <= acc_s1;
			corr_s2 <= corr_s1;
		end
	end

	// Stage 3: merge lanes, add accumulator, sum mulh partials, combine counts
	always_comb begin
		lo_d = '0;
		hi_d = '0;
		mid  = '0;
		lz   = '0;
		run  = 1'b1;
		for (int c = CLS_CHUNKS - 1; c >= 0; c--) begin
			if (run) begin
				lz = lz + {3'd0, cnt_s2[c]};
			end
			if (cnt_s2[c] != 4'(CHUNK_W)) begin
				run = 1'b0;
			end
		end
		case (kind_s2)
			K_MUL_LOW: lo_d = prod_s2.wp[0];
			K_MADD:    lo_d = acc_s2 + prod_s2.wp[0];
			K_MULH: begin
				lo_d = prod_s2.wp[1] + {32'd0, prod_s2.wp[2][63:32]} +
					{32'd0, prod_s2.wp[3][63:32]};
				mid = {2'd0, prod_s2.wp[0][63:32]} + {2'd0, prod_s2.wp[2][31:0]} +
					{2'd0, prod_s2.wp[3][31:0]};
			end
			K_VEC8: begin
				lo_d = {prod_s2.bp[3], prod_s2.bp[2], prod_s2.bp[1], prod_s2.bp[0]};
				hi_d = {prod_s2.bp[7], prod_s2.bp[6], prod_s2.bp[5], prod_s2.bp[4]};
			end
			K_VEC4: begin
				lo_d = {prod_s2.hp[1], prod_s2.hp[0]};
				hi_d = {prod_s2.hp[3], prod_s2.hp[2]};
			end
			K_VEC2: begin
				lo_d = prod_s2.wp[0];
				hi_d = prod_s2.wp[1];
			end
			// the top marked bit is always clear, so the count is at least one
			K_CLS:     lo_d = {57'd0, lz - 7'd1};
			default:   lo_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			kind_s3  <= kind_s2;
			lo_s3    <= lo_d;
			hi_s3    <= hi_d;
			carry_s3 <= mid[33:32];
			corr_s3  <= corr_s2;
		end
	end

	// Stage 4: add the middle carry and sign fix-up for the high product
	always_comb begin
		rsp_d.result_low  = lo_s3;
		rsp_d.result_high = hi_s3;
		rsp_d.handled     = (kind_s3 != K_NONE);
		if (kind_s3 == K_MULH) begin
			rsp_d.result_low = lo_s3 + {62'd0, carry_s3} - corr_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			rsp_s4 <= rsp_d;
		end
	end

	// A full pipeline with a stalled receiver takes nothing new
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !rsp_ready) |-> !req_ready)
		else $error("req_ready high while pipeline is full and stalled");

	// The handled flag follows the decoded class into the output
	a_handled: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv4) |=> (rsp_data.handled == ($past(kind_s3) != K_NONE)))
		else $error("handled flag does not match decoded class");

	// Only vector forms produce a high word
	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv4 && kind_s3 != K_VEC8 && kind_s3 != K_VEC4 && kind_s3 != K_VEC2)
		|=> (rsp_data.result_high == 64'd0))
		else $error("nonzero high word for a scalar result");

	// A sign count never reaches 64
	a_cls_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv4 && kind_s3 == K_CLS) |=> (rsp_data.result_low[63:6] == '0))
		else $error("cls count out of range");

endmodule
